FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros, disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/atm_pkg.sv
// ----------------------------------------------------------------------------
// atm_pkg
// types, codes and constants of the alarm table matcher
// ----------------------------------------------------------------------------
package atm_pkg;

    localparam int ALARM_COUNT_DEF = 8;
    localparam logic [2:0] DAYS_IN_WEEK = 3'd7;
    localparam logic [7:0] ENTRY_DAYS_MASK = 8'h7F;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_ACK   = 2'd2;

    localparam logic REG_CHIME_BEGIN = 1'b0;
    localparam logic REG_CHIME_END   = 1'b1;

    typedef struct packed {
        logic       enabled;
        logic [6:0] days;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [7:0] sound;
    } t_entry;

    function automatic logic in_window(logic [4:0] lo, logic [4:0] hi, logic [4:0] h);
        logic r;
        if (lo < hi) begin
            r = (h >= lo) && (h < hi);
        end else if (lo > hi) begin
            r = (h >= lo) || (h < hi);
        end else begin
            r = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: hdl/alarm_table_matcher_top.sv
// ----------------------------------------------------------------------------
// alarm_table_matcher_top
// real-time-clock alarm compare: chime window check and alarm table scan
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_ready) carries one beat per item: a minute
// tick, an alarm entry write or an acknowledge. every item yields exactly one
// result beat on the output channel (o_out_valid / i_out_ready).
// the table lives in a one-port-read synchronous ram of ALARM_COUNT entries;
// a tick reads one entry a cycle and then loads its result; a write or unused
// beat goes straight to the result step; an acknowledge reads the remembered
// slot and then, for a one-shot entry, writes it back with its enable cleared.
// the block works on one item at a time and takes the next beat in the cycle
// after the previous result was loaded into the output register.
// the output register holds a result while the receiver stalls; the next item
// is still taken and processed, and waits in its last step until the output
// register frees up.
// synchronous reset clears all valid bits of the table (every alarm disabled),
// the remembered slot and the chime registers; no clearing pass is needed.
// chime window registers sit on the apb port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alarm_table_matcher_top #(
    parameter int ALARM_COUNT = atm_pkg::ALARM_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [2:0]  i_weekday,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [2:0]  i_slot,
    input  logic        i_entry_enabled,
    input  logic [7:0]  i_entry_days,
    input  logic [7:0]  i_entry_sound,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_chime,
    output logic        o_alarm_hit,
    output logic [2:0]  o_hit_slot,
    output logic [7:0]  o_hit_sound,
    output logic        o_one_shot_cleared
);
    import atm_pkg::*;

    localparam int AW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
    localparam int XW = (AW > 3) ? AW : 3;
    localparam logic [AW-1:0] LAST_IDX = AW'(ALARM_COUNT - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_ACK  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [4:0]    r_begin, r_end;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_last, n_last;
    logic [2:0]    r_day, n_day;
    logic [4:0]    r_hour, n_hour;
    logic [5:0]    r_minute, n_minute;

    logic          r_res_chime, n_res_chime;
    logic          r_res_hit, n_res_hit;
    logic [2:0]    r_res_slot, n_res_slot;
    logic [7:0]    r_res_sound, n_res_sound;
    logic          r_res_clr, n_res_clr;

    logic          r_out_valid, n_out_valid;
    logic          r_out_chime, r_out_hit, r_out_clr;
    logic [2:0]    r_out_slot;
    logic [7:0]    r_out_sound;

    t_entry        r_mem [ALARM_COUNT];
    logic [ALARM_COUNT-1:0] r_vld;
    t_entry        r_rd_data;
    logic          r_rd_vld;

    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        entry;
    logic          in_acc;
    logic          cfg_wr;
    logic [XW-1:0] slot_x;
    logic [XW-1:0] idx_x;
    logic          day_ok;
    logic          entry_hit;
    logic          out_free;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign slot_x   = XW'(i_slot);
    assign idx_x    = XW'(r_idx);
    assign entry    = r_rd_vld ? r_rd_data : '0;
    assign out_free = !r_out_valid || i_out_ready;

    assign day_ok    = entry.days[r_day] || (entry.days == 7'd0);
    assign entry_hit = entry.enabled && day_ok && (entry.hour == r_hour)
                       && (entry.minute == r_minute);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin <= '0;
            r_end   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_CHIME_BEGIN: r_begin <= pwdata[4:0];
                REG_CHIME_END:   r_end   <= pwdata[4:0];
                default:         r_end   <= r_end;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CHIME_BEGIN: prdata = 32'(r_begin);
            REG_CHIME_END:   prdata = 32'(r_end);
            default:         prdata = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_last      = r_last;
        n_day       = r_day;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_res_chime = r_res_chime;
        n_res_hit   = r_res_hit;
        n_res_slot  = r_res_slot;
        n_res_sound = r_res_sound;
        n_res_clr   = r_res_clr;
        n_out_valid = r_out_valid;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = slot_x[AW-1:0];
        wr_data     = '0;
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    n_res_chime = 1'b0;
                    n_res_hit   = 1'b0;
                    n_res_slot  = '0;
                    n_res_sound = '0;
                    n_res_clr   = 1'b0;
                    n_day       = (i_weekday == DAYS_IN_WEEK) ? 3'd0 : i_weekday;
                    n_hour      = i_hour;
                    n_minute    = i_minute;
                    n_state     = S_DONE;
                    priority if (i_func == FUNC_TICK) begin
                        n_res_chime = (i_minute == 6'd0) && in_window(r_begin, r_end, i_hour);
                        n_idx       = '0;
                        rd_addr     = '0;
                        n_state     = S_SCAN;
                    end else if (i_func == FUNC_WRITE) begin
                        if (32'(i_slot) < ALARM_COUNT) begin
                            wr_en   = 1'b1;
                            wr_addr = slot_x[AW-1:0];
                            wr_data = '{enabled: i_entry_enabled,
                                        days:    i_entry_days[6:0] & ENTRY_DAYS_MASK[6:0],
                                        hour:    i_hour,
                                        minute:  i_minute,
                                        sound:   i_entry_sound};
                        end
                    end else if (i_func == FUNC_ACK) begin
                        rd_addr = r_last;
                        n_state = S_ACK;
                    end else begin
                        // unused code: all-zero result
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                rd_addr = (r_idx == LAST_IDX) ? '0 : r_idx + AW'(1);
                n_idx   = rd_addr;
                if (entry_hit) begin
                    n_res_hit   = 1'b1;
                    n_res_slot  = idx_x[2:0];
                    n_res_sound = entry.sound;
                    n_last      = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end
            end
            S_ACK: begin
                if (entry.days == 7'd0) begin
                    n_res_clr = entry.enabled;
                    wr_en     = 1'b1;
                    wr_addr   = r_last;
                    wr_data   = entry;
                    wr_data.enabled = 1'b0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_day       <= n_day;
        r_hour      <= n_hour;
        r_minute    <= n_minute;
        r_res_chime <= n_res_chime;
        r_res_hit   <= n_res_hit;
        r_res_slot  <= n_res_slot;
        r_res_sound <= n_res_sound;
        r_res_clr   <= n_res_clr;
        if (r_state == S_DONE && out_free) begin
            r_out_chime <= r_res_chime;
            r_out_hit   <= r_res_hit;
            r_out_slot  <= r_res_slot;
            r_out_sound <= r_res_sound;
            r_out_clr   <= r_res_clr;
        end
    end

    // alarm table ram
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

    assign o_out_valid        = r_out_valid;
    assign o_chime            = r_out_chime;
    assign o_alarm_hit        = r_out_hit;
    assign o_hit_slot         = r_out_slot;
    assign o_hit_sound        = r_out_sound;
    assign o_one_shot_cleared = r_out_clr;

    `ASSERT_IMPL(a_hit_excl_clr, i_clk, i_rst_n, o_out_valid, !(o_alarm_hit && o_one_shot_cleared))
    `ASSERT_IMPL(a_nohit_zero, i_clk, i_rst_n, o_out_valid && !o_alarm_hit, (o_hit_slot == 3'd0) && (o_hit_sound == 8'd0))
    `ASSERT_NEXT(a_ack_reads, i_clk, i_rst_n, in_acc && (i_func == FUNC_ACK), r_state == S_ACK)
    `ASSERT_IMPL(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_idx <= LAST_IDX)

endmodule
